// ===== rtl/core/ctms_pkg.sv =====
// Shared types and constants for the capacitive touch matrix scanner.
// Used by ctms_measure and capacitive_touch_matrix_scanner; no dependencies.
package ctms_pkg;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_CAL1,
    PH_CAL2,
    PH_SCAN1,
    PH_SCAN2
  } phase_e;

  // Input word kinds.
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_STOP  = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;
  localparam logic [CfgIdxW-1:0] CFG_COUNT_LIMIT  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_THR_SCALE    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_CAP_ROW_MASK = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_CAL_TICKS    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_PRESSED_LVL  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_DRIVE_POL    = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_PIN_PRESENT  = 3'd6;

  // Register values after reset.
  localparam logic [7:0]  RST_COUNT_LIMIT = 8'd250;
  localparam logic [2:0]  RST_THR_SCALE   = 3'd2;
  localparam logic [15:0] RST_CAL_TICKS   = 16'd100;
  localparam logic [63:0] RST_PIN_PRESENT = '1;

  // One tick of a charge-time measurement.
  typedef struct packed {
    logic       drive;
    logic       half_switch;
    logic       done;
    logic [7:0] count;
    logic [8:0] edge_next;
  } meas_t;

  // One result word.
  typedef struct packed {
    logic       drive_level;
    logic [2:0] row_index;
    logic [7:0] row_value;
    logic       row_valid;
    logic       scan_done;
    logic       matrix_changed;
    logic       calibrating;
    logic [7:0] active_capacitive_rows;
  } result_t;

  // Lowest set bit of v: bit 3 set when v is zero, else bits 2:0 give its index.
  function automatic logic [3:0] first_set(input logic [7:0] v);
    logic [3:0] r;
    r = 4'b1000;
    for (int i = 7; i >= 0; i--) begin
      if (v[i]) begin
        r = {1'b0, 3'(i)};
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/capacitive_touch_matrix_scanner.sv =====
// Top level of the capacitive touch matrix scanner: control state, calibration,
// row scan and the output register with skid stage. Depends on ctms_pkg, ctms_measure.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_stall_o  | kind_i, sense_level_i, column_levels_i
//   out     | output    | out_valid_o / out_stall_i| drive_level_o .. active_capacitive_rows_o
//   cfg     | input     | cfg_we_i                 | cfg_index_i, cfg_wdata_i
//
// One tick word is accepted per clock while the skid register is empty; its result
// word is registered and shows on the next cycle unless the output is stalled.
// All per-tick work is one pass through the measurement step and row logic.
// A skid register behind the output register keeps input accepting for one
// extra word while the output is stalled; in_stall_o rises once the skid is full.
// Reset clears all control state, thresholds and matrices, and loads configuration reset values.
module capacitive_touch_matrix_scanner #(
  parameter int unsigned ROWS = 8,
  parameter int unsigned COLS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    kind_i,
  input  logic                          sense_level_i,
  input  logic [7:0]                    column_levels_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          drive_level_o,
  output logic [2:0]                    row_index_o,
  output logic [7:0]                    row_value_o,
  output logic                          row_valid_o,
  output logic                          scan_done_o,
  output logic                          matrix_changed_o,
  output logic                          calibrating_o,
  output logic [7:0]                    active_capacitive_rows_o,
  input  logic                          cfg_we_i,
  input  logic [ctms_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ctms_pkg::CfgDataW-1:0] cfg_wdata_i
);

  localparam int unsigned RowIdxW  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [7:0]  RowsMask = 8'((9'd1 << ROWS) - 9'd1);
  localparam logic [2:0]  LastRow  = 3'(ROWS - 1);

  // Configuration registers.
  logic [7:0]  count_limit_q;
  logic [2:0]  thr_scale_q;
  logic [7:0]  cap_mask_q;
  logic [15:0] cal_ticks_q;
  logic        pressed_q;
  logic        polarity_q;
  logic [63:0] pin_mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_limit_q <= ctms_pkg::RST_COUNT_LIMIT;
      thr_scale_q   <= ctms_pkg::RST_THR_SCALE;
      cap_mask_q    <= '0;
      cal_ticks_q   <= ctms_pkg::RST_CAL_TICKS;
      pressed_q     <= 1'b0;
      polarity_q    <= 1'b0;
      pin_mask_q    <= ctms_pkg::RST_PIN_PRESENT;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ctms_pkg::CFG_COUNT_LIMIT:  count_limit_q <= cfg_wdata_i[7:0];
        ctms_pkg::CFG_THR_SCALE:    thr_scale_q   <= cfg_wdata_i[2:0];
        ctms_pkg::CFG_CAP_ROW_MASK: cap_mask_q    <= cfg_wdata_i[7:0];
        ctms_pkg::CFG_CAL_TICKS:    cal_ticks_q   <= cfg_wdata_i[15:0];
        ctms_pkg::CFG_PRESSED_LVL:  pressed_q     <= cfg_wdata_i[0];
        ctms_pkg::CFG_DRIVE_POL:    polarity_q    <= cfg_wdata_i[0];
        ctms_pkg::CFG_PIN_PRESENT:  pin_mask_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Scanner state.
  ctms_pkg::phase_e phase_q, phase_d;
  logic [2:0]  row_ptr_q, row_ptr_d;
  logic [8:0]  edge_q, edge_d;
  logic [7:0]  cal_max_q, cal_max_d;
  logic [15:0] win_q, win_d;
  logic [7:0]  enabled_q, enabled_d;
  logic        drive_q, drive_d;
  logic [7:0]  thr_q  [ROWS];
  logic [7:0]  thr_d  [ROWS];
  logic [7:0]  scan_q [ROWS];
  logic [7:0]  scan_d [ROWS];
  logic [7:0]  prev_q [ROWS];
  logic [7:0]  prev_d [ROWS];

  logic                 accept;
  logic [RowIdxW-1:0]   row_sel;
  ctms_pkg::meas_t      meas;
  ctms_pkg::result_t    res;
  logic [15:0]          win_inc;
  logic [7:0]           max_new;
  logic [10:0]          prod;
  logic [7:0]           thr_val;
  logic [7:0]           direct_row;
  logic [7:0]           above_mask;
  logic [3:0]           first_en;
  logic [3:0]           next_en;
  logic [2:0]           row_out;
  logic [7:0]           rv;
  logic                 finished;
  logic                 changed;
  logic                 sdone;

  assign row_sel = row_ptr_q[RowIdxW-1:0];

  ctms_measure u_measure (
    .second_i      ((phase_q == ctms_pkg::PH_CAL2) || (phase_q == ctms_pkg::PH_SCAN2)),
    .sense_i       (sense_level_i),
    .polarity_i    (polarity_q),
    .edge_cnt_i    (edge_q),
    .count_limit_i (count_limit_q),
    .meas_o        (meas)
  );

  assign win_inc    = (win_q == 16'hFFFF) ? win_q : win_q + 16'd1;
  assign max_new    = (meas.count > cal_max_q) ? meas.count : cal_max_q;
  assign prod       = 11'(max_new) * 11'(thr_scale_q);
  assign thr_val    = (|prod[10:8]) ? 8'hFF : prod[7:0];
  assign above_mask = ~((8'd2 << row_ptr_q) - 8'd1);
  assign first_en   = ctms_pkg::first_set(cap_mask_q & RowsMask);

  // Direct row: a bit per present pin whose level matches the pressed level.
  always_comb begin
    direct_row = '0;
    for (int c = 0; c < COLS; c++) begin
      direct_row[c] = pin_mask_q[{row_ptr_q, 3'(c)}] & ~(column_levels_i[c] ^ pressed_q);
    end
  end

  always_comb begin
    phase_d   = phase_q;
    row_ptr_d = row_ptr_q;
    edge_d    = edge_q;
    cal_max_d = cal_max_q;
    win_d     = win_q;
    enabled_d = enabled_q;
    drive_d   = drive_q;
    thr_d     = thr_q;
    scan_d    = scan_q;
    prev_d    = prev_q;
    row_out   = row_ptr_q;
    rv        = '0;
    finished  = 1'b0;
    changed   = 1'b0;
    sdone     = 1'b0;
    next_en   = 4'b1000;

    case (kind_i)
      ctms_pkg::KIND_START: begin
        for (int r = 0; r < ROWS; r++) begin
          thr_d[r] = '0;
        end
        enabled_d = cap_mask_q & RowsMask;
        edge_d    = '0;
        win_d     = '0;
        cal_max_d = '0;
        if (!first_en[3]) begin
          phase_d   = ctms_pkg::PH_CAL1;
          row_ptr_d = first_en[2:0];
        end else begin
          phase_d   = ctms_pkg::PH_SCAN1;
          row_ptr_d = '0;
        end
        row_out = row_ptr_d;
      end
      ctms_pkg::KIND_STOP: begin
        phase_d   = ctms_pkg::PH_IDLE;
        row_ptr_d = '0;
        edge_d    = '0;
        win_d     = '0;
        row_out   = '0;
      end
      default: begin
        unique case (phase_q) inside
          ctms_pkg::PH_CAL1, ctms_pkg::PH_CAL2: begin
            win_d   = win_inc;
            drive_d = meas.drive;
            edge_d  = meas.edge_next;
            if (meas.half_switch) begin
              phase_d = ctms_pkg::PH_CAL2;
            end
            if (meas.done) begin
              phase_d   = ctms_pkg::PH_CAL1;
              cal_max_d = max_new;
              if (win_inc >= cal_ticks_q) begin
                // Window over: a row whose maximum count reaches the limit is not a sensor.
                if (max_new == count_limit_q) begin
                  enabled_d[row_ptr_q] = 1'b0;
                end else begin
                  thr_d[row_sel] = thr_val;
                end
                win_d     = '0;
                cal_max_d = '0;
                edge_d    = '0;
                next_en   = ctms_pkg::first_set(enabled_d & above_mask);
                if (!next_en[3]) begin
                  phase_d   = ctms_pkg::PH_CAL1;
                  row_ptr_d = next_en[2:0];
                end else begin
                  phase_d   = ctms_pkg::PH_SCAN1;
                  row_ptr_d = '0;
                end
              end
            end
          end
          ctms_pkg::PH_SCAN1, ctms_pkg::PH_SCAN2: begin
            if (enabled_q[row_ptr_q]) begin
              drive_d = meas.drive;
              edge_d  = meas.edge_next;
              if (meas.half_switch) begin
                phase_d = ctms_pkg::PH_SCAN2;
              end
              if (meas.done) begin
                phase_d  = ctms_pkg::PH_SCAN1;
                rv       = {8{meas.count > thr_q[row_sel]}};
                finished = 1'b1;
              end
            end else begin
              rv       = direct_row;
              phase_d  = ctms_pkg::PH_SCAN1;
              finished = 1'b1;
            end
            if (finished) begin
              scan_d[row_sel] = rv;
              if (row_ptr_q == LastRow) begin
                sdone = 1'b1;
                for (int r = 0; r < ROWS; r++) begin
                  if (scan_d[r] != prev_q[r]) begin
                    changed = 1'b1;
                  end
                end
                prev_d    = scan_d;
                row_ptr_d = '0;
              end else begin
                row_ptr_d = row_ptr_q + 3'd1;
              end
            end
          end
          default: ;
        endcase
      end
    endcase

    res.drive_level            = drive_d;
    res.row_index              = row_out;
    res.row_value              = rv;
    res.row_valid              = finished;
    res.scan_done              = sdone;
    res.matrix_changed         = changed;
    res.calibrating            = (phase_d == ctms_pkg::PH_CAL1) ||
                                 (phase_d == ctms_pkg::PH_CAL2);
    res.active_capacitive_rows = enabled_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= ctms_pkg::PH_IDLE;
      row_ptr_q <= '0;
      edge_q    <= '0;
      cal_max_q <= '0;
      win_q     <= '0;
      enabled_q <= '0;
      drive_q   <= 1'b0;
      for (int r = 0; r < ROWS; r++) begin
        thr_q[r]  <= '0;
        scan_q[r] <= '0;
        prev_q[r] <= '0;
      end
    end else if (accept) begin
      phase_q   <= phase_d;
      row_ptr_q <= row_ptr_d;
      edge_q    <= edge_d;
      cal_max_q <= cal_max_d;
      win_q     <= win_d;
      enabled_q <= enabled_d;
      drive_q   <= drive_d;
      thr_q     <= thr_d;
      scan_q    <= scan_d;
      prev_q    <= prev_d;
    end
  end

  // Output register with one skid word behind it.
  ctms_pkg::result_t out_q, skid_q;
  logic out_valid_q, skid_valid_q;
  logic out_free;

  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i & ~skid_valid_q;
  assign out_free   = ~out_valid_q | ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q | accept;
      skid_valid_q <= 1'b0;
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (accept) begin
        out_q <= res;
      end
    end else if (accept) begin
      skid_q <= res;
    end
  end

  assign out_valid_o              = out_valid_q;
  assign drive_level_o            = out_q.drive_level;
  assign row_index_o              = out_q.row_index;
  assign row_value_o              = out_q.row_value;
  assign row_valid_o              = out_q.row_valid;
  assign scan_done_o              = out_q.scan_done;
  assign matrix_changed_o         = out_q.matrix_changed;
  assign calibrating_o            = out_q.calibrating;
  assign active_capacitive_rows_o = out_q.active_capacitive_rows;

endmodule

// ===== rtl/core/ctms_measure.sv =====
// Single-tick step of the charge-time measurement: drive level, half switch,
// finish detection and the next edge count. Depends on ctms_pkg.
module ctms_measure (
  input  logic             second_i,
  input  logic             sense_i,
  input  logic             polarity_i,
  input  logic [8:0]       edge_cnt_i,
  input  logic [7:0]       count_limit_i,
  output ctms_pkg::meas_t  meas_o
);

  logic [8:0] edge_inc;
  logic       over;

  assign edge_inc = edge_cnt_i + 9'd1;
  assign over     = edge_inc > {1'b0, count_limit_i};

  always_comb begin
    meas_o             = '0;
    meas_o.edge_next   = edge_cnt_i;
    if (!second_i) begin
      meas_o.drive = polarity_i;
      if (sense_i == polarity_i) begin
        // The pin followed: move to the return half without counting.
        meas_o.half_switch = 1'b1;
      end else begin
        meas_o.edge_next = edge_inc;
        if (over) begin
          meas_o.done  = 1'b1;
          meas_o.count = count_limit_i;
        end
      end
    end else begin
      meas_o.drive = ~polarity_i;
      if (sense_i != polarity_i) begin
        meas_o.done  = 1'b1;
        meas_o.count = edge_cnt_i[7:0];
      end else begin
        meas_o.edge_next = edge_inc;
        if (over) begin
          meas_o.done  = 1'b1;
          meas_o.count = count_limit_i;
        end
      end
    end
    if (meas_o.done) begin
      meas_o.edge_next = '0;
    end
  end

endmodule
